/* src/ucmm_pkg.sv */
// Package with the shared widths, defaults and sweep control type of the coverage statistics block.
package ucmm_pkg;

   localparam int CLAMP_BIN_DEF = 1000;
   localparam int BIN_WIDTH_DEF = 32;

   localparam int COPIES_W = 8;
   localparam int COV_W    = 16;
   localparam int OUT_W    = 10;
   localparam int SUM_W    = 48;
   localparam int CNT_W    = 32;

   // Only entries that occur exactly once in the graph are counted.
   localparam logic [COPIES_W-1:0] UNIQUE_COPIES = COPIES_W'(1);

   // Control for the histogram sweep evaluator.
   typedef struct packed {
      logic init;      // Clear the running median and mode state.
      logic vld;       // A histogram bin's count is on the read data.
      logic mode_bin;  // The bin takes part in the mode search.
   } sweep_ctl_type;

endpackage

/* src/unique_coverage_median_mode.sv */
// Top level of the unique-entry coverage statistics block: intake, histogram update and report.
//
// Each input transfer is one index entry. Entries with a graph copy count of exactly one add their
// read coverage to a saturating 48-bit sum, add one to a saturating 32-bit count, and add one to a
// histogram bin (coverage at or above CLAMP_BIN lands in bin CLAMP_BIN). While the block streams,
// entries are taken at one per cycle: the histogram sits in a single-port-read, single-port-write
// memory and each update is a read in the cycle of the transfer and a write in the next cycle,
// with the freshly written count forwarded when back-to-back entries hit the same bin. An entry
// with last set closes the batch: the block then stalls its input while the last write lands,
// the memory read port walks every bin once to find the median and the mode, each bin is written
// back to zero, and the result is reported. The result transfer then carries the median, the mode
// (never the clamp bin), the sum and the count, and the totals start again from zero. A result
// that waits on the output does not hold up the next batch's entries. After reset the input
// stalls while the memory is cleared one bin per cycle.
module unique_coverage_median_mode #(
   parameter int CLAMP_BIN = ucmm_pkg::CLAMP_BIN_DEF,
   parameter int BIN_WIDTH = ucmm_pkg::BIN_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ucmm_pkg::COPIES_W-1:0]   req_graph_copies,
   input  logic [ucmm_pkg::COV_W-1:0]      req_read_coverage,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ucmm_pkg::OUT_W-1:0]      rsp_median_coverage,
   output logic [ucmm_pkg::OUT_W-1:0]      rsp_mode_coverage,
   output logic [ucmm_pkg::SUM_W-1:0]      rsp_coverage_sum,
   output logic [ucmm_pkg::CNT_W-1:0]      rsp_unique_entries
);

   import ucmm_pkg::*;

   localparam int NBINS = CLAMP_BIN + 1;
   localparam int IDX_W = $clog2(NBINS);
   localparam int MED_W = $clog2(CLAMP_BIN + 2);
   localparam int MED_X = (MED_W > OUT_W) ? MED_W : OUT_W;
   localparam int IDX_X = (IDX_W > OUT_W) ? IDX_W : OUT_W;
   localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(CLAMP_BIN);

   // CLEAR walks the memory after reset, SETTLE lets the last entry's write land, SWEEP issues
   // one bin read per cycle, DRAIN evaluates the final bin and REPORT hands off the result.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RUN,
      ST_SETTLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_REPORT
   } state_type;

   state_type            st_ff;
   logic [IDX_W-1:0]     addr_ff;

   // Update pipeline: the stage after the memory read, and the last write for forwarding.
   logic                 s1_vld_ff;
   logic [IDX_W-1:0]     s1_bin_ff;
   logic                 fwd_vld_ff;
   logic [IDX_W-1:0]     fwd_bin_ff;
   logic [BIN_WIDTH-1:0] fwd_val_ff;

   // Sweep data stage.
   logic                 sw_vld_ff;
   logic [IDX_W-1:0]     sw_bin_ff;

   logic [SUM_W-1:0]     sum_ff;
   logic [CNT_W-1:0]     cnt_ff;

   logic                 rsp_valid_ff;
   logic [OUT_W-1:0]     rsp_median_ff;
   logic [OUT_W-1:0]     rsp_mode_ff;
   logic [SUM_W-1:0]     rsp_sum_ff;
   logic [CNT_W-1:0]     rsp_cnt_ff;

   logic                 accept;
   logic                 unique_in;
   logic [IDX_W-1:0]     bin_in;
   logic [SUM_W:0]       sum_wide;
   logic [SUM_W-1:0]     sum_in;
   logic [CNT_W-1:0]     cnt_in;
   logic                 report_go;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [BIN_WIDTH-1:0] wr_data;
   logic [IDX_W-1:0]     rd_addr;
   logic [BIN_WIDTH-1:0] rd_data;
   logic [BIN_WIDTH-1:0] bin_cur;
   logic [BIN_WIDTH-1:0] bin_inc;

   sweep_ctl_type        sw_ctl;
   logic [MED_W-1:0]     median;
   logic [IDX_W-1:0]     mode;
   logic [MED_X-1:0]     median_x;
   logic [IDX_X-1:0]     mode_x;

   // Entries are only taken while streaming; the output register decouples the result side.
   assign req_stall = (st_ff != ST_RUN);
   assign accept    = req_valid && !req_stall;
   assign unique_in = (req_graph_copies == UNIQUE_COPIES);

   // Coverage at or above the clamp goes to the clamp bin.
   assign bin_in = ({1'b0, req_read_coverage} < (COV_W + 1)'(CLAMP_BIN)) ?
                   IDX_W'(req_read_coverage) : LAST_BIN;

   // Saturating totals.
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(req_read_coverage);
   assign sum_in   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
   assign cnt_in   = (cnt_ff == {CNT_W{1'b1}}) ? cnt_ff : cnt_ff + CNT_W'(1);

   // A bin written in the previous cycle is not yet visible in this cycle's read data.
   assign bin_cur = (fwd_vld_ff && (fwd_bin_ff == s1_bin_ff)) ? fwd_val_ff : rd_data;
   assign bin_inc = (bin_cur == {BIN_WIDTH{1'b1}}) ? bin_cur : bin_cur + BIN_WIDTH'(1);

   // The clear pass, the sweep write-back and the update never fall in the same cycle.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      if (st_ff == ST_CLEAR) begin
         wr_en = 1'b1;
      end else if (sw_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = sw_bin_ff;
      end else if (s1_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = s1_bin_ff;
         wr_data = bin_inc;
      end
   end

   assign rd_addr = (st_ff == ST_RUN) ? bin_in : addr_ff;

   ucmm_hist_ram #(
      .DEPTH (NBINS),
      .AW    (IDX_W),
      .DW    (BIN_WIDTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sw_ctl.init     = (st_ff == ST_SETTLE);
   assign sw_ctl.vld      = sw_vld_ff;
   assign sw_ctl.mode_bin = (sw_bin_ff != LAST_BIN);

   ucmm_sweep #(
      .CLAMP_BIN (CLAMP_BIN),
      .BIN_WIDTH (BIN_WIDTH),
      .IDX_W     (IDX_W),
      .MED_W     (MED_W)
   ) u_sweep (
      .clock     (clock),
      .ctl       (sw_ctl),
      .bin       (sw_bin_ff),
      .bin_count (rd_data),
      .half      (cnt_ff[CNT_W-1:1]),
      .median    (median),
      .mode      (mode)
   );

   assign median_x  = MED_X'(median);
   assign mode_x    = IDX_X'(mode);
   assign report_go = (st_ff == ST_REPORT) && (!rsp_valid_ff || !rsp_stall);

   // Datapath registers of the update and sweep pipelines.
   always_ff @(posedge clock) begin
      s1_bin_ff  <= bin_in;
      fwd_bin_ff <= s1_bin_ff;
      fwd_val_ff <= bin_inc;
      sw_bin_ff  <= addr_ff;
      if (report_go) begin
         rsp_median_ff <= median_x[OUT_W-1:0];
         rsp_mode_ff   <= mode_x[OUT_W-1:0];
         rsp_sum_ff    <= sum_ff;
         rsp_cnt_ff    <= cnt_ff;
      end
   end

   // Sequencer, pipeline valids, totals and the result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_CLEAR;
         addr_ff      <= '0;
         s1_vld_ff    <= 1'b0;
         fwd_vld_ff   <= 1'b0;
         sw_vld_ff    <= 1'b0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= accept && unique_in;
         fwd_vld_ff <= s1_vld_ff;
         sw_vld_ff  <= (st_ff == ST_SWEEP);

         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (accept && unique_in) begin
            sum_ff <= sum_in;
            cnt_ff <= cnt_in;
         end

         case (st_ff)
            ST_CLEAR: begin
               addr_ff <= addr_ff + IDX_W'(1);
               if (addr_ff == LAST_BIN) begin
                  st_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (accept && req_last) begin
                  st_ff <= ST_SETTLE;
               end
            end
            ST_SETTLE: begin
               addr_ff <= '0;
               st_ff   <= ST_SWEEP;
            end
            ST_SWEEP: begin
               addr_ff <= addr_ff + IDX_W'(1);
               if (addr_ff == LAST_BIN) begin
                  st_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               st_ff <= ST_REPORT;
            end
            ST_REPORT: begin
               if (report_go) begin
                  rsp_valid_ff <= 1'b1;
                  sum_ff       <= '0;
                  cnt_ff       <= '0;
                  st_ff        <= ST_RUN;
               end
            end
            default: begin
               st_ff <= ST_CLEAR;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_median_coverage = rsp_median_ff;
   assign rsp_mode_coverage   = rsp_mode_ff;
   assign rsp_coverage_sum    = rsp_sum_ff;
   assign rsp_unique_entries  = rsp_cnt_ff;

   // The entry update and the sweep write-back must never compete for the write port.
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(s1_vld_ff && sw_vld_ff))
      else $error("histogram update and sweep write-back in the same cycle");

   // Swept bins stay inside the histogram.
   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      sw_vld_ff |-> (sw_bin_ff <= LAST_BIN))
      else $error("sweep bin beyond the clamp bin");

   // A new result is raised only by the report step.
   a_rsp_from_report: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(st_ff) == ST_REPORT))
      else $error("result raised outside the report step");

   // The last entry of a batch always leads into the sweep.
   a_last_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |=> (st_ff == ST_SETTLE))
      else $error("last entry did not start the sweep");

endmodule

/* src/ucmm_hist_ram.sv */
// Histogram memory: one write port and one read port with a registered read.
module ucmm_hist_ram #(
   parameter int DEPTH = ucmm_pkg::CLAMP_BIN_DEF + 1,
   parameter int AW    = $clog2(DEPTH),
   parameter int DW    = ucmm_pkg::BIN_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ucmm_sweep.sv */
// Sweep evaluator: walks the histogram bins in order and tracks the median and the mode.
module ucmm_sweep #(
   parameter int CLAMP_BIN = ucmm_pkg::CLAMP_BIN_DEF,
   parameter int BIN_WIDTH = ucmm_pkg::BIN_WIDTH_DEF,
   parameter int IDX_W     = $clog2(CLAMP_BIN + 1),
   parameter int MED_W     = $clog2(CLAMP_BIN + 2)
) (
   input  logic                          clock,
   input  ucmm_pkg::sweep_ctl_type       ctl,
   input  logic [IDX_W-1:0]              bin,
   input  logic [BIN_WIDTH-1:0]          bin_count,
   input  logic [ucmm_pkg::CNT_W-2:0]    half,
   output logic [MED_W-1:0]              median,
   output logic [IDX_W-1:0]              mode
);

   import ucmm_pkg::*;

   // The running total only grows while it is below half, so one bin past half fits.
   localparam int SEEN_W = ((BIN_WIDTH > CNT_W - 1) ? BIN_WIDTH : CNT_W - 1) + 1;

   logic [SEEN_W-1:0]    seen_ff;
   logic [MED_W-1:0]     median_ff;
   logic [IDX_W-1:0]     mode_ff;
   logic [BIN_WIDTH-1:0] best_ff;

   always_ff @(posedge clock) begin
      if (ctl.init) begin
         seen_ff   <= '0;
         median_ff <= '0;
         mode_ff   <= '0;
         best_ff   <= '0;
      end else if (ctl.vld) begin
         if (seen_ff < SEEN_W'(half)) begin
            seen_ff   <= seen_ff + SEEN_W'(bin_count);
            median_ff <= median_ff + MED_W'(1);
         end
         // Strict compare keeps the first bin among equal counts.
         if (ctl.mode_bin && (bin_count > best_ff)) begin
            best_ff <= bin_count;
            mode_ff <= bin;
         end
      end
   end

   assign median = median_ff;
   assign mode   = mode_ff;

endmodule
